### src/dmch_pkg.sv
package dmch_pkg;

    // defaults for the top-level parameters
    localparam int unsigned MAX_INDEX_BITS_DEF = 10;
    localparam int unsigned LEVELS_DEF         = 3;
    localparam int unsigned ADDRESS_BITS_DEF   = 32;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_INDEX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_INDEX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_INDEX     = 3'd5;

    // filter modes
    localparam logic [1:0] FILTER_UNIFIED = 2'd0;
    localparam logic [1:0] FILTER_INSTR   = 2'd1;
    localparam logic [1:0] FILTER_DATA    = 2'd2;

    // reference kind and command codes
    localparam logic KIND_INSTR = 1'b0;
    localparam logic KIND_DATA  = 1'b1;
    localparam logic CMD_WRITE  = 1'b1;

    // line offset clamp
    localparam logic [3:0] OFFSET_MIN = 4'd2;
    localparam logic [3:0] OFFSET_MAX = 4'd12;

    // reset values of the configuration registers
    localparam logic [1:0] RST_FILTER_MODE = FILTER_UNIFIED;
    localparam logic [3:0] RST_OFFSET_BITS = 4'd4;
    localparam logic [1:0] RST_LEVEL_COUNT = 2'd1;
    localparam logic [3:0] RST_L1_INDEX    = 4'd8;
    localparam logic [3:0] RST_L2_INDEX    = 4'd10;
    localparam logic [3:0] RST_L3_INDEX    = 4'd10;

    // shift amounts reach at most 12 + 15
    localparam int unsigned SHIFT_W = 5;
    localparam int unsigned IB_W    = 5;

    // result fields
    localparam int unsigned HIT_W      = 2;
    localparam int unsigned MASK_W     = 3;
    localparam int unsigned OUT_DATA_W = 8;

    localparam int unsigned QUEUE_DEPTH = 2;

    // classification of one reference, handed from front to back
    typedef struct packed {
        logic       skip;
        logic       write;
        logic [1:0] used;
    } dmch_ctl_t;

    localparam int unsigned CTL_W = $bits(dmch_ctl_t);

endpackage

### src/dmch_ram.sv
module dmch_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/dmch_queue.sv
module dmch_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= din;
        end
    end

endmodule

### src/dmch_front.sv
module dmch_front #(
    parameter int unsigned MAX_INDEX_BITS = 10,
    parameter int unsigned LEVELS         = 3,
    parameter int unsigned ADDRESS_BITS   = 32
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_we,
    input  logic [dmch_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [dmch_pkg::CFG_DATA_W-1:0]           cfg_wdata,
    input  logic                                      ref_kind,
    input  logic                                      command,
    input  logic [ADDRESS_BITS-1:0]                   address,
    output dmch_pkg::dmch_ctl_t                       ctl,
    output logic [LEVELS-1:0][MAX_INDEX_BITS-1:0]     idx,
    output logic [LEVELS-1:0][ADDRESS_BITS-3:0]       tag
);

    import dmch_pkg::*;

    logic [1:0]      filter_mode_reg;
    logic [3:0]      offset_bits_reg;
    logic [1:0]      level_count_reg;
    logic [2:0][3:0] index_bits_reg;

    logic [3:0]      ob;
    logic [1:0]      used;
    logic [ADDRESS_BITS-1:0] lo_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg   <= RST_FILTER_MODE;
            offset_bits_reg   <= RST_OFFSET_BITS;
            level_count_reg   <= RST_LEVEL_COUNT;
            index_bits_reg[0] <= RST_L1_INDEX;
            index_bits_reg[1] <= RST_L2_INDEX;
            index_bits_reg[2] <= RST_L3_INDEX;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FILTER_MODE: begin
                    filter_mode_reg <= cfg_wdata[1:0];
                end
                CFG_OFFSET_BITS: begin
                    offset_bits_reg <= cfg_wdata;
                end
                CFG_LEVEL_COUNT: begin
                    level_count_reg <= cfg_wdata[1:0];
                end
                CFG_L1_INDEX: begin
                    index_bits_reg[0] <= cfg_wdata;
                end
                CFG_L2_INDEX: begin
                    index_bits_reg[1] <= cfg_wdata;
                end
                CFG_L3_INDEX: begin
                    index_bits_reg[2] <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // clamp offset and level count; filter mode three acts as unified
    always_comb begin
        ob = offset_bits_reg;
        if (ob < OFFSET_MIN) begin
            ob = OFFSET_MIN;
        end
        if (ob > OFFSET_MAX) begin
            ob = OFFSET_MAX;
        end
        used = (level_count_reg == 2'd0) ? 2'd1 : level_count_reg;
        if (int'(used) > LEVELS) begin
            used = 2'(LEVELS);
        end
    end

    assign ctl.skip  = ((filter_mode_reg == FILTER_INSTR) && (ref_kind != KIND_INSTR)) ||
                       ((filter_mode_reg == FILTER_DATA)  && (ref_kind != KIND_DATA));
    assign ctl.write = (command == CMD_WRITE);
    assign ctl.used  = used;

    assign lo_bits = address >> ob;

    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        logic [IB_W-1:0]           ib;
        logic [MAX_INDEX_BITS-1:0] idx_mask;
        logic [ADDRESS_BITS-1:0]   hi_bits;

        always_comb begin
            ib = {1'b0, index_bits_reg[l]};
            if (ib > IB_W'(MAX_INDEX_BITS)) begin
                ib = IB_W'(MAX_INDEX_BITS);
            end
            for (int j = 0; j < MAX_INDEX_BITS; j++) begin
                idx_mask[j] = (j < int'(ib));
            end
        end

        assign hi_bits = address >> (SHIFT_W'(ob) + SHIFT_W'(ib));
        assign idx[l]  = lo_bits[MAX_INDEX_BITS-1:0] & idx_mask;
        assign tag[l]  = hi_bits[ADDRESS_BITS-3:0];
    end

endmodule

### src/dmch_back.sv
module dmch_back #(
    parameter int unsigned MAX_INDEX_BITS = 10,
    parameter int unsigned LEVELS         = 3,
    parameter int unsigned ADDRESS_BITS   = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_empty,
    input  dmch_pkg::dmch_ctl_t                   q_ctl,
    input  logic [LEVELS-1:0][MAX_INDEX_BITS-1:0] q_idx,
    input  logic [LEVELS-1:0][ADDRESS_BITS-3:0]   q_tag,
    output logic                                  q_pop,
    output logic                                  clr_done,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [dmch_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                  m_tuser
);

    import dmch_pkg::*;

    localparam int unsigned TW    = ADDRESS_BITS - 2;
    localparam int unsigned WW    = TW + 2;
    localparam int unsigned DEPTH = 2 ** MAX_INDEX_BITS;

    localparam logic [1:0] BST_CLEAR = 2'd0;
    localparam logic [1:0] BST_IDLE  = 2'd1;
    localparam logic [1:0] BST_EVAL  = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [MAX_INDEX_BITS-1:0]           clr_cnt_reg;
    dmch_ctl_t                           ctl_reg;
    logic [LEVELS-1:0][MAX_INDEX_BITS-1:0] idx_reg;
    logic [LEVELS-1:0][TW-1:0]           tag_reg;

    logic                                m_tvalid_reg;
    logic [OUT_DATA_W-1:0]               m_tdata_reg;
    logic                                m_tuser_reg;

    logic [LEVELS-1:0][WW-1:0]           rd_word;
    logic [LEVELS-1:0][WW-1:0]           upd_word;
    logic [LEVELS-1:0]                   upd_we;
    logic [HIT_W-1:0]                    hit;
    logic [MASK_W-1:0]                   victims;
    logic                                found;

    logic clearing, out_free, commit;

    assign clearing = (state_reg == BST_CLEAR);
    assign clr_done = !clearing;
    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == BST_IDLE) && !q_empty;
    assign commit   = (state_reg == BST_EVAL) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BST_CLEAR: begin
                if (clr_cnt_reg == '1) begin
                    state_next = BST_IDLE;
                end
            end
            BST_IDLE: begin
                if (!q_empty) begin
                    state_next = BST_EVAL;
                end
            end
            BST_EVAL: begin
                if (out_free) begin
                    state_next = BST_IDLE;
                end
            end
            default: begin
                state_next = BST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // item under work
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ctl_reg <= q_ctl;
            idx_reg <= q_idx;
            tag_reg <= q_tag;
        end
        if (commit) begin
            m_tuser_reg <= !ctl_reg.skip;
            m_tdata_reg <= OUT_DATA_W'({victims, hit});
        end
    end

    // walk the levels in order; a hit ends the walk
    always_comb begin
        found    = 1'b0;
        hit      = '0;
        victims  = '0;
        upd_we   = '0;
        upd_word = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (!ctl_reg.skip && !found && (l < int'(ctl_reg.used))) begin
                if (rd_word[l][WW-1] && (rd_word[l][TW-1:0] == tag_reg[l])) begin
                    found = 1'b1;
                    hit   = HIT_W'(l + 1);
                    if (ctl_reg.write) begin
                        upd_we[l]   = 1'b1;
                        upd_word[l] = {1'b1, 1'b1, tag_reg[l]};
                    end
                end else begin
                    victims[l]  = rd_word[l][WW-1] && rd_word[l][WW-2];
                    upd_we[l]   = 1'b1;
                    upd_word[l] = {1'b1, 1'b0, tag_reg[l]};
                end
            end
        end
    end

    // one word per line: valid, dirty, tag
    for (genvar l = 0; l < LEVELS; l++) begin : g_ram
        logic                      ram_we;
        logic [MAX_INDEX_BITS-1:0] ram_waddr;
        logic [WW-1:0]             ram_wdata;

        assign ram_we    = clearing || (commit && upd_we[l]);
        assign ram_waddr = clearing ? clr_cnt_reg : idx_reg[l];
        assign ram_wdata = clearing ? '0 : upd_word[l];

        dmch_ram #(
            .WIDTH (WW),
            .DEPTH (DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (q_pop),
            .raddr (q_idx[l]),
            .rdata (rd_word[l])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### src/direct_mapped_cache_hierarchy_core.sv
// Channel  | Dir | Ports                         | Contents
// ---------+-----+-------------------------------+-----------------------------------------
// s_       | in  | s_tvalid s_tready s_tdata     | tdata: address; tuser: ref_kind, command
// m_       | out | m_tvalid m_tready m_tdata     | tdata: hit_level, dirty_victim_mask
//          |     | m_tuser                       | tuser: accepted
// cfg_     | in  | cfg_we cfg_index cfg_wdata    | register writes, no read-back
//
// The back finishes one reference before it takes the next: the registered read of the
// per-level tag RAMs is issued in IDLE, the compare and write-back follow in EVAL.
// A reference passes the queue, the tag RAM read register and the result register.
// After reset a clearing pass over all 2**MAX_INDEX_BITS lines wipes the valid and dirty
// bits; s_tready stays low for its length. Configuration writes are taken throughout.
// A two-entry queue sits between the front and the back; a stalled m_ side fills it,
// then drops s_tready.
module direct_mapped_cache_hierarchy_core #(
    parameter int unsigned MAX_INDEX_BITS = dmch_pkg::MAX_INDEX_BITS_DEF,
    parameter int unsigned LEVELS         = dmch_pkg::LEVELS_DEF,
    parameter int unsigned ADDRESS_BITS   = dmch_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((ADDRESS_BITS+7)/8)*8-1:0]      s_tdata,  // address, zero padding above
    input  logic [1:0]                             s_tuser,  // [0] ref_kind, [1] command

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [dmch_pkg::OUT_DATA_W-1:0]        m_tdata,  // [1:0] hit_level,
                                                             // [4:2] dirty_victim_mask
    output logic                                   m_tuser,  // accepted

    input  logic                                   cfg_we,
    input  logic [dmch_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dmch_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    import dmch_pkg::*;

    localparam int unsigned TW      = ADDRESS_BITS - 2;
    localparam int unsigned ENTRY_W = CTL_W + LEVELS * (MAX_INDEX_BITS + TW);

    dmch_ctl_t                             f_ctl, b_ctl;
    logic [LEVELS-1:0][MAX_INDEX_BITS-1:0] f_idx, b_idx;
    logic [LEVELS-1:0][TW-1:0]             f_tag, b_tag;
    logic [ENTRY_W-1:0]                    q_din, q_dout;
    logic                                  q_full, q_empty, q_pop, q_push;
    logic                                  clr_done;

    // front: config registers, kind filter, index/tag split per level
    dmch_front #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .LEVELS         (LEVELS),
        .ADDRESS_BITS   (ADDRESS_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ref_kind  (s_tuser[0]),
        .command   (s_tuser[1]),
        .address   (s_tdata[ADDRESS_BITS-1:0]),
        .ctl       (f_ctl),
        .idx       (f_idx),
        .tag       (f_tag)
    );

    // input is held off until the clearing pass is over
    assign s_tready = clr_done && !q_full;
    assign q_push   = s_tvalid && s_tready;
    assign q_din    = {f_ctl, f_idx, f_tag};

    dmch_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    assign {b_ctl, b_idx, b_tag} = q_dout;

    // back: tag RAM probe, hit/victim decision, line update, result register
    dmch_back #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .LEVELS         (LEVELS),
        .ADDRESS_BITS   (ADDRESS_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_ctl    (b_ctl),
        .q_idx    (b_idx),
        .q_tag    (b_tag),
        .q_pop    (q_pop),
        .clr_done (clr_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### sim/dmch_outcome_checker.sv
// Watches both channels and the register port of the cache hierarchy.
// Keeps a private copy of the tag, valid and dirty stores, predicts the
// outcome of every accepted reference and compares it in order.
module dmch_outcome_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // address
    input  logic [1:0]                       s_tuser,   // [0] ref_kind, [1] command
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [dmch_pkg::OUT_DATA_W-1:0]  m_tdata,   // [1:0] hit_level, [4:2] victim mask
    input  logic                             m_tuser,   // accepted
    input  logic                             cfg_we,
    input  logic [dmch_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dmch_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int unsigned                      pending_count,
    output int unsigned                      fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import dmch_pkg::*;

    localparam int unsigned LINES = 1 << MAX_INDEX_BITS_DEF;

    typedef struct packed {
        logic                accepted;
        logic [HIT_W-1:0]    hit_level;
        logic [MASK_W-1:0]   victim_mask;
    } outcome_t;

    logic [29:0] line_tag   [LEVELS_DEF][LINES];
    bit          line_valid [LEVELS_DEF][LINES];
    bit          line_dirty [LEVELS_DEF][LINES];

    logic [1:0]  filter_mode;
    logic [3:0]  offset_bits;
    logic [1:0]  level_count;
    logic [3:0]  index_bits [LEVELS_DEF];

    outcome_t    expected_outcomes [$];

    // walk the levels, updating the private stores as the hardware should
    function automatic outcome_t probe_hierarchy(logic kind, logic wr, logic [31:0] addr);
        outcome_t    res;
        int unsigned ob, used, ib, lv, idx;
        logic [29:0] tag;
        bit          found;
        res = '0;
        if ((filter_mode == FILTER_INSTR && kind != KIND_INSTR) ||
            (filter_mode == FILTER_DATA && kind != KIND_DATA))
            return res;
        res.accepted = 1'b1;
        ob = offset_bits;
        if (ob < OFFSET_MIN) ob = OFFSET_MIN;
        if (ob > OFFSET_MAX) ob = OFFSET_MAX;
        used = (level_count == 0) ? 1 : level_count;
        if (used > LEVELS_DEF) used = LEVELS_DEF;
        found = 1'b0;
        for (lv = 0; lv < used && !found; lv++) begin
            ib  = (index_bits[lv] > MAX_INDEX_BITS_DEF) ? MAX_INDEX_BITS_DEF : index_bits[lv];
            idx = (addr >> ob) & ((1 << ib) - 1);
            tag = 30'(addr >> (ob + ib));
            if (line_valid[lv][idx] && line_tag[lv][idx] == tag) begin
                if (wr == CMD_WRITE) line_dirty[lv][idx] = 1'b1;
                res.hit_level = HIT_W'(lv + 1);
                found = 1'b1;
            end else begin
                if (line_valid[lv][idx] && line_dirty[lv][idx]) res.victim_mask[lv] = 1'b1;
                // fill is always clean, writes included
                line_tag[lv][idx]   = tag;
                line_valid[lv][idx] = 1'b1;
                line_dirty[lv][idx] = 1'b0;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        outcome_t want, got;
        if (!aresetn) begin
            foreach (line_valid[l, i]) begin
                line_valid[l][i] = 1'b0;
                line_dirty[l][i] = 1'b0;
            end
            filter_mode   = RST_FILTER_MODE;
            offset_bits   = RST_OFFSET_BITS;
            level_count   = RST_LEVEL_COUNT;
            index_bits[0] = RST_L1_INDEX;
            index_bits[1] = RST_L2_INDEX;
            index_bits[2] = RST_L3_INDEX;
            expected_outcomes.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FILTER_MODE: filter_mode   = cfg_wdata[1:0];
                    CFG_OFFSET_BITS: offset_bits   = cfg_wdata;
                    CFG_LEVEL_COUNT: level_count   = cfg_wdata[1:0];
                    CFG_L1_INDEX:    index_bits[0] = cfg_wdata;
                    CFG_L2_INDEX:    index_bits[1] = cfg_wdata;
                    CFG_L3_INDEX:    index_bits[2] = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_outcomes.push_back(probe_hierarchy(s_tuser[0], s_tuser[1], s_tdata));
            if (m_tvalid && m_tready) begin
                got.accepted    = m_tuser;
                got.hit_level   = m_tdata[1:0];
                got.victim_mask = m_tdata[4:2];
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, got %0h",
                             $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got !== want) begin
                        if (got.accepted !== want.accepted)
                            $display("%0t: accepted expected %0d, got %0d",
                                     $time, want.accepted, got.accepted);
                        if (got.hit_level !== want.hit_level)
                            $display("%0t: hit_level expected %0d, got %0d",
                                     $time, want.hit_level, got.hit_level);
                        if (got.victim_mask !== want.victim_mask)
                            $display("%0t: dirty_victim_mask expected %b, got %b",
                                     $time, want.victim_mask, got.victim_mask);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count <= expected_outcomes.size();
    end

endmodule

### sim/direct_mapped_cache_hierarchy_core_test.sv
// Top of the cache hierarchy bench: clock, reset, reference stimulus,
// result sink with random back-pressure, register programming and verdict.
// All checking happens in dmch_outcome_checker.
module direct_mapped_cache_hierarchy_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dmch_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 10;
    // clearing pass plus ~550 refs at worst-case stalls, times several
    localparam int CYCLE_LIMIT    = 300000;
    localparam int REFS_PER_PHASE = 53;
    localparam int HOT_LINES      = 16;
    localparam int MAX_WAIT       = 17;
    // leave some slack after the last result before touching registers
    localparam int DRAIN_CYCLES   = 8;

    localparam logic       CMD_READ          = ~CMD_WRITE;
    // undefined filter code, behaves as unified
    localparam logic [1:0] FILTER_MODE_THREE = 2'd3;

    typedef struct packed {
        logic [1:0] filter;
        logic [3:0] offset;
        logic [1:0] count;
        logic [3:0] l1_index;
        logic [3:0] l2_index;
        logic [3:0] l3_index;
    } cache_setup_t;

    // tiny levels so the directed walk can force misses and dirty evictions per level
    localparam cache_setup_t DIRECTED_SETUP =
        '{FILTER_UNIFIED, 4'd4, 2'd3, 4'd0, 4'd1, 4'd2};

    // random phases: covers offset and index saturation, level count zero to three,
    // every filter code, single-line levels
    localparam int N_PHASES = 8;
    localparam cache_setup_t RANDOM_PHASES [N_PHASES] = '{
        '{FILTER_UNIFIED,    4'd4,  2'd3, 4'd2,  4'd4,  4'd6},
        '{FILTER_UNIFIED,    4'd2,  2'd3, 4'd0,  4'd3,  4'd10},
        '{FILTER_UNIFIED,    4'd12, 2'd2, 4'd10, 4'd10, 4'd10},
        '{FILTER_MODE_THREE, 4'd15, 2'd3, 4'd1,  4'd2,  4'd3},
        '{FILTER_INSTR,      4'd0,  2'd0, 4'd2,  4'd5,  4'd8},
        '{FILTER_DATA,       4'd5,  2'd3, 4'd15, 4'd15, 4'd15},
        '{FILTER_UNIFIED,    4'd3,  2'd1, 4'd4,  4'd0,  4'd0},
        '{FILTER_UNIFIED,    4'd6,  2'd3, 4'd3,  4'd1,  4'd0}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int unsigned pending_count;
    int unsigned fail_count;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;           // both sides skip their waits while set
    logic [31:0] hot_lines [HOT_LINES];    // reused addresses so lines actually hit

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    direct_mapped_cache_hierarchy_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    dmch_outcome_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .pending_count (pending_count),
        .fail_count    (fail_count)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // mostly addresses near the hot set: same line, or one bit away (often a
    // conflicting line in some level); the rest fully random
    function automatic logic [31:0] pick_address();
        int unsigned roll;
        logic [31:0] addr;
        roll = $urandom_range(0, 99);
        addr = hot_lines[$urandom_range(0, HOT_LINES - 1)];
        if (roll < 55)
            addr[3:0] = 4'($urandom);
        else if (roll < 85)
            addr = addr ^ (32'd1 << $urandom_range(2, 17));
        else
            addr = $urandom;
        return addr;
    endfunction

    // one reference transfer; s_tvalid stays high on return so a back-to-back
    // transfer needs no extra edge
    task automatic send_ref(input logic kind, input logic cmd, input logic [31:0] addr);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= {cmd, kind};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // stop sending, wait for every outstanding result, then let the pipe empty
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
    endtask

    // all six registers back to back, write enable held across them
    task automatic program_cache(input cache_setup_t setup);
        put_register(CFG_FILTER_MODE, CFG_DATA_W'(setup.filter));
        put_register(CFG_OFFSET_BITS, setup.offset);
        put_register(CFG_LEVEL_COUNT, CFG_DATA_W'(setup.count));
        put_register(CFG_L1_INDEX,    setup.l1_index);
        put_register(CFG_L2_INDEX,    setup.l2_index);
        put_register(CFG_L3_INDEX,    setup.l3_index);
        cfg_we <= 1'b0;
    endtask

    // result side: random stall before each result, sometimes none at all
    initial begin : result_sink
        int unsigned stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = draw_wait();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        cache_setup_t setup;
        int unsigned  taken, sent;
        int           p;
        logic         kind, cmd;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed: line size 16, L1 one line, L2 two lines, L3 four lines ----
        // s_tready stays low through the clearing pass; the handshake covers it
        program_cache(DIRECTED_SETUP);
        send_ref(KIND_INSTR, CMD_READ,  32'h0000_0000);  // cold miss everywhere
        send_ref(KIND_DATA,  CMD_READ,  32'h0000_0004);  // L1 hit, same line
        send_ref(KIND_DATA,  CMD_WRITE, 32'h0000_0008);  // L1 write hit -> dirty
        send_ref(KIND_DATA,  CMD_READ,  32'h0000_0010);  // evicts dirty L1 line
        send_ref(KIND_DATA,  CMD_WRITE, 32'h0000_0000);  // L2 write hit -> dirty
        send_ref(KIND_INSTR, CMD_READ,  32'h0000_0040);  // evicts dirty L2 line
        send_ref(KIND_INSTR, CMD_READ,  32'h0000_0020);  // pushes 0x40 out of L1/L2 only
        send_ref(KIND_DATA,  CMD_WRITE, 32'h0000_0040);  // L3 write hit -> dirty
        send_ref(KIND_DATA,  CMD_READ,  32'h0000_0100);  // evicts dirty L3 line
        send_ref(KIND_DATA,  CMD_WRITE, 32'hFFFF_FFFF);  // top address, miss
        send_ref(KIND_DATA,  CMD_WRITE, 32'hFFFF_FFFF);  // hit, dirty
        send_ref(KIND_INSTR, CMD_READ,  32'h7FFF_FFFF);  // dirty L1 victim again

        // kind filter: skipped references must leave the stores alone
        settle_idle();
        setup = DIRECTED_SETUP;
        setup.filter = FILTER_INSTR;
        program_cache(setup);
        send_ref(KIND_DATA,  CMD_WRITE, 32'h7FFF_FFF0);  // skipped
        send_ref(KIND_INSTR, CMD_WRITE, 32'h7FFF_FFF0);  // hit, line not dirtied by skip

        settle_idle();
        setup.filter = FILTER_DATA;
        program_cache(setup);
        send_ref(KIND_INSTR, CMD_READ,  32'h1234_5670);  // skipped
        send_ref(KIND_DATA,  CMD_READ,  32'h7FFF_FFF8);  // hit, written line kept

        settle_idle();
        setup.filter = FILTER_MODE_THREE;
        program_cache(setup);
        send_ref(KIND_INSTR, CMD_READ,  32'hA5A5_A5A0);
        send_ref(KIND_DATA,  CMD_READ,  32'h5A5A_5A50);

        // ---- random phases; stored tags carry over between settings ----
        for (p = 0; p < N_PHASES; p++) begin
            settle_idle();
            program_cache(RANDOM_PHASES[p]);
            foreach (hot_lines[j]) hot_lines[j] = $urandom;
            taken = 0;
            sent  = 0;
            // skipped references do not count toward the phase
            while (taken < REFS_PER_PHASE) begin
                if (sent % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
                if (sent % 25 == 24) hot_lines[$urandom_range(0, HOT_LINES - 1)] = $urandom;
                kind = 1'($urandom);
                cmd  = 1'($urandom);
                send_ref(kind, cmd, pick_address());
                sent++;
                if (!((RANDOM_PHASES[p].filter == FILTER_INSTR && kind != KIND_INSTR) ||
                      (RANDOM_PHASES[p].filter == FILTER_DATA && kind != KIND_DATA)))
                    taken++;
                // in the first phase, hold the sender once mid-phase until every result is back
                if (p == 0 && sent == REFS_PER_PHASE / 2) settle_idle();
            end
        end

        no_idle = 1'b0;
        settle_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
